>>> hw/rtl/soft_knee_gain_computer_assert.svh
// Assertion macros shared by the gain computer RTL.
`ifndef SOFT_KNEE_GAIN_COMPUTER_ASSERT_SVH
`define SOFT_KNEE_GAIN_COMPUTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SKGC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gain computer assertion failed");

// Next-cycle implication, checked outside reset.
`define SKGC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gain computer assertion failed");

`endif

>>> hw/rtl/skgc_pkg.sv
// Shared constants, types and codes of the soft-knee gain computer.
package skgc_pkg;

  localparam int FRAC_BITS = 8;
  localparam int LVL_W = 17;
  localparam int KNEE_W = 14;
  localparam int RATIO_W = 15;
  localparam int QW = 26;   // quotient bits, covers every reachable quotient
  localparam int NW = 49;   // dividend magnitude bits
  localparam int DW = 32;   // divisor bits

  localparam logic [16:0] ONE_Q = 17'(1) << FRAC_BITS;
  localparam int RATIO_FLOOR = ((1 << FRAC_BITS) + 99) / 100;
  localparam logic signed [33:0] MIN_DB_W = -(34'sd144 <<< FRAC_BITS);
  localparam logic signed [27:0] OUT_MAX = 28'sd65535;
  localparam logic signed [27:0] OUT_MIN = -28'sd65536;

  typedef enum logic [1:0] {
    REGION_BELOW = 2'd0,
    REGION_KNEE  = 2'd1,
    REGION_ABOVE = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_KNEE      = 2'd1,
    CFG_RATIO     = 2'd2
  } cfg_index_t;

  // One item on its way through the divider stages.
  typedef struct packed {
    logic [NW-1:0]           rem;
    logic [DW-1:0]           den;
    logic [QW-1:0]           q;
    logic                    neg;
    logic signed [LVL_W-1:0] base;
    region_t                 region;
  } div_item_t;

endpackage

>>> hw/rtl/skgc_prep.sv
// Front stages: clamping, region test, products and dividend setup.
module skgc_prep (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic signed [skgc_pkg::LVL_W-1:0]       level,
  input  logic signed [skgc_pkg::LVL_W-1:0]       thr,
  input  logic [skgc_pkg::KNEE_W-1:0]             knee,
  input  logic [skgc_pkg::RATIO_W-1:0]            ratio,
  output logic                                    out_valid,
  output skgc_pkg::div_item_t                     out_item
);

  // Stage A: clamp operands, find the region.
  logic signed [33:0] xw, tw;
  logic signed [16:0] x_c, t_c;
  logic [13:0] k_c;
  logic [14:0] r_c;
  logic signed [17:0] d;
  logic signed [18:0] twod, kk, e_full;
  skgc_pkg::region_t region_a;

  always_comb begin
    xw = 34'(level);
    tw = 34'(thr);
    x_c = (xw < skgc_pkg::MIN_DB_W) ? skgc_pkg::MIN_DB_W[16:0] : level;
    if (tw < skgc_pkg::MIN_DB_W) begin
      t_c = skgc_pkg::MIN_DB_W[16:0];
    end else if (tw > 34'sd0) begin
      t_c = '0;
    end else begin
      t_c = thr;
    end
    k_c = (knee == '0) ? 14'd1 : knee;
    r_c = (ratio < 15'(skgc_pkg::RATIO_FLOOR)) ? 15'(skgc_pkg::RATIO_FLOOR) : ratio;
    d = 18'(x_c) - 18'(t_c);
    twod = 19'(d) <<< 1;
    kk = $signed({5'b0, k_c});
    if (twod < -kk) begin
      region_a = skgc_pkg::REGION_BELOW;
    end else if (twod <= kk) begin
      region_a = skgc_pkg::REGION_KNEE;
    end else begin
      region_a = skgc_pkg::REGION_ABOVE;
    end
    e_full = twod + kk;
  end

  logic va_r;
  logic signed [16:0] base_a_r;
  skgc_pkg::region_t region_a_r;
  logic signed [17:0] d_a_r;
  logic [15:0] e_a_r;
  logic [13:0] k_a_r;
  logic [14:0] r_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
    if (en) begin
      base_a_r <= (region_a == skgc_pkg::REGION_ABOVE) ? t_c : x_c;
      region_a_r <= region_a;
      d_a_r <= d;
      e_a_r <= e_full[15:0];
      k_a_r <= k_c;
      r_a_r <= r_c;
    end
  end

  // Stage B: square of the knee offset, knee times ratio, gain magnitudes.
  logic vb_r;
  logic signed [16:0] base_b_r;
  skgc_pkg::region_t region_b_r;
  logic [31:0] e2_b_r;
  logic [28:0] kr_b_r;
  logic [16:0] gmag_b_r;
  logic [17:0] dmag_b_r;
  logic [14:0] r_b_r;
  logic neg_b_r;
  logic r_over;

  assign r_over = {2'b0, r_a_r} > skgc_pkg::ONE_Q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
    if (en) begin
      base_b_r <= base_a_r;
      region_b_r <= region_a_r;
      e2_b_r <= 32'(e_a_r) * 32'(e_a_r);
      kr_b_r <= 29'(k_a_r) * 29'(r_a_r);
      gmag_b_r <= r_over ? ({2'b0, r_a_r} - skgc_pkg::ONE_Q)
                         : (skgc_pkg::ONE_Q - {2'b0, r_a_r});
      dmag_b_r <= d_a_r[17] ? 18'(-d_a_r) : d_a_r;
      r_b_r <= r_a_r;
      neg_b_r <= (region_a_r == skgc_pkg::REGION_KNEE) ? r_over : d_a_r[17];
    end
  end

  // Stage C: dividend magnitude and divisor.
  logic vc_r;
  logic signed [16:0] base_c_r;
  skgc_pkg::region_t region_c_r;
  logic [skgc_pkg::NW-1:0] mag_c_r;
  logic [skgc_pkg::DW-1:0] den_c_r;
  logic neg_c_r;
  logic [skgc_pkg::NW-1:0] mag_c;
  logic [skgc_pkg::DW-1:0] den_c;

  always_comb begin
    case (region_b_r)
      skgc_pkg::REGION_KNEE: begin
        mag_c = skgc_pkg::NW'(gmag_b_r) * skgc_pkg::NW'(e2_b_r);
        den_c = skgc_pkg::DW'(kr_b_r) << 3;
      end
      skgc_pkg::REGION_ABOVE: begin
        mag_c = skgc_pkg::NW'(dmag_b_r) << skgc_pkg::FRAC_BITS;
        den_c = skgc_pkg::DW'(r_b_r);
      end
      default: begin
        mag_c = '0;
        den_c = skgc_pkg::DW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
    if (en) begin
      base_c_r <= base_b_r;
      region_c_r <= region_b_r;
      mag_c_r <= mag_c;
      den_c_r <= den_c;
      neg_c_r <= neg_b_r;
    end
  end

  // Stage D: add half the divisor so the quotient rounds half away from zero.
  logic vd_r;
  skgc_pkg::div_item_t item_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
    if (en) begin
      item_d_r.rem <= mag_c_r + skgc_pkg::NW'(den_c_r >> 1);
      item_d_r.den <= den_c_r;
      item_d_r.q <= '0;
      item_d_r.neg <= neg_c_r;
      item_d_r.base <= base_c_r;
      item_d_r.region <= region_c_r;
    end
  end

  assign out_valid = vd_r;
  assign out_item = item_d_r;

endmodule

>>> hw/rtl/skgc_div_step.sv
// One restoring division step that settles a single quotient bit.
module skgc_div_step #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  skgc_pkg::div_item_t in_item,
  output logic                out_valid,
  output skgc_pkg::div_item_t out_item
);

  localparam int CW = skgc_pkg::DW + skgc_pkg::QW;

  logic [CW-1:0] trial;
  logic ge;
  skgc_pkg::div_item_t item_nxt;

  always_comb begin
    trial = CW'(in_item.den) << BIT;
    ge = CW'(in_item.rem) >= trial;
    item_nxt = in_item;
    if (ge) begin
      item_nxt.rem = in_item.rem - trial[skgc_pkg::NW-1:0];
      item_nxt.q[BIT] = 1'b1;
    end
  end

  logic valid_r;
  skgc_pkg::div_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item = item_r;

endmodule

>>> hw/rtl/soft_knee_gain_computer.sv
// Top level of the soft-knee compressor gain computer.
// The block maps one input level in dB (signed Q8.8) to the compressor's static
// output level: unchanged below the knee, a quadratic blend inside it, and
// threshold plus overshoot divided by the ratio above it. Each result also
// carries the region code and a flag that is set when the level was clipped to
// the 17-bit signed range. A new beat is accepted every cycle unless the output
// stalls. The pipeline has four front stages for clamping, products and rounding
// setup, one stage for each of the 26 quotient bits of the pipelined divider, and
// one output stage. The whole pipeline advances together, so a stall on the
// output holds every stage in place. Configuration is written through a plain
// write port and should only change while no beat is in flight.
`include "soft_knee_gain_computer_assert.svh"

module soft_knee_gain_computer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [16:0] level_in_db, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] level_out_db, rest zero
  output logic [2:0]  out_tuser,  // [1:0] region, [2] saturated
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);

  localparam int QW = skgc_pkg::QW;

  // Configuration registers, stored as written and clamped downstream.
  logic signed [16:0] thr_r;
  logic [13:0] knee_r;
  logic [14:0] ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= -17'sd5120;
      knee_r <= 14'd1536;
      ratio_r <= 15'd1024;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        skgc_pkg::CFG_THRESHOLD: thr_r <= cfg_wdata;
        skgc_pkg::CFG_KNEE:      knee_r <= cfg_wdata[13:0];
        skgc_pkg::CFG_RATIO:     ratio_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Every stage moves when the output register is empty or being drained.
  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  logic                stage_v [QW+1];
  skgc_pkg::div_item_t stage_item [QW+1];

  skgc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .level     ($signed(in_tdata[16:0])),
    .thr       (thr_r),
    .knee      (knee_r),
    .ratio     (ratio_r),
    .out_valid (stage_v[0]),
    .out_item  (stage_item[0])
  );

  // Quotient bits are resolved from the most significant one down.
  for (genvar g = 0; g < QW; g++) begin : g_div
    skgc_div_step #(.BIT(QW - 1 - g)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (stage_v[g]),
      .in_item   (stage_item[g]),
      .out_valid (stage_v[g+1]),
      .out_item  (stage_item[g+1])
    );
  end

  // Output stage: apply the sign, add the base level, saturate.
  skgc_pkg::div_item_t fin;
  logic signed [27:0] qs, y;
  logic signed [16:0] y_sat;
  logic sat;

  always_comb begin
    fin = stage_item[QW];
    qs = $signed({2'b0, fin.q});
    y = 28'(fin.base) + (fin.neg ? -qs : qs);
    if (y > skgc_pkg::OUT_MAX) begin
      y_sat = skgc_pkg::OUT_MAX[16:0];
      sat = 1'b1;
    end else if (y < skgc_pkg::OUT_MIN) begin
      y_sat = skgc_pkg::OUT_MIN[16:0];
      sat = 1'b1;
    end else begin
      y_sat = y[16:0];
      sat = 1'b0;
    end
  end

  logic signed [16:0] level_out_r;
  skgc_pkg::region_t region_out_r;
  logic sat_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stage_v[QW];
    end
    if (en) begin
      level_out_r <= y_sat;
      region_out_r <= fin.region;
      sat_out_r <= sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'b0, level_out_r};
  assign out_tuser = {sat_out_r, region_out_r};

  // A level below the knee passes unchanged and can never clip.
  `SKGC_ASSERT(a_below_no_sat, out_valid_r && region_out_r == skgc_pkg::REGION_BELOW, !sat_out_r)
  // A clipped result sits exactly on one of the range limits.
  `SKGC_ASSERT(a_sat_at_limit, out_valid_r && sat_out_r, level_out_r == 17'sh0FFFF || level_out_r == -17'sd65536)
  // While the output stalls, the divider does not advance a valid item.
  `SKGC_ASSERT_NEXT(a_stall_holds, out_valid_r && !out_tready && stage_v[QW], stage_v[QW] && $stable(stage_item[QW].q))

endmodule
